[hw/rtl/crystal_fiber_membership_test_defines.svh]
// Assertion macros used by the checker file.
`ifndef CRYSTAL_FIBER_MEMBERSHIP_TEST_DEFINES_SVH
`define CRYSTAL_FIBER_MEMBERSHIP_TEST_DEFINES_SVH

// Checked at every clock edge outside reset.
`define CFMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CFMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cfmt_pkg.sv]
`default_nettype none
package cfmt_pkg;

  localparam int SYM_COUNT_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;

  localparam int FIELD_W     = 18;
  localparam int IDX_W       = 5;
  localparam int DIR_W       = 3 * FIELD_W;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 18;

  // Input item kinds, carried in tuser.
  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_X = 2'd0,
    REG_SAMPLE_Y = 2'd1,
    REG_SAMPLE_Z = 2'd2,
    REG_COS_TOL  = 2'd3
  } cfg_reg_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MPROD,
    BK_MSUM,
    BK_WALK,
    BK_DRAIN,
    BK_SEND
  } back_state_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] w;
  } quat_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage
`default_nettype wire

[hw/rtl/cfmt_ram.sv]
`default_nettype none
module cfmt_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 24,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/cfmt_front.sv]
`default_nettype none
module cfmt_front #(
  parameter int SYM_COUNT = 24,
  localparam int ADDR_W = (SYM_COUNT > 1) ? $clog2(SYM_COUNT) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [cfmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             in_tuser,
  input  wire cfmt_pkg::back_status_t           bk_status,
  output logic                                  ram_we,
  output logic [ADDR_W-1:0]                     ram_waddr,
  output logic [cfmt_pkg::DIR_W-1:0]            ram_wdata,
  output logic                                  q_valid,
  output cfmt_pkg::quat_t                       q_data,
  input  wire logic                             q_pop
);
  import cfmt_pkg::*;

  op_t        op;
  logic       accept;
  logic       push;
  logic [5:0] idx_ext;
  quat_t      q_in;
  quat_t      qmem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign op      = op_t'(in_tuser);
  assign idx_ext = {1'b0, in_tdata[IDX_W-1:0]};
  assign q_in.w  = in_tdata[76:59];
  assign q_in.x  = in_tdata[94:77];
  assign q_in.y  = in_tdata[112:95];
  assign q_in.z  = in_tdata[130:113];

  // A load waits until all classify work has drained; a classify needs a free slot.
  always_comb begin
    case (op)
      OP_LOAD:     in_tready = (count_r == 2'd0) && !bk_status.busy;
      OP_CLASSIFY: in_tready = (count_r != 2'd2);
      default:     in_tready = 1'b0;
    endcase
  end

  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (op == OP_CLASSIFY);
  assign ram_we    = accept && (op == OP_LOAD) && (idx_ext < 6'(SYM_COUNT));
  assign ram_waddr = idx_ext[ADDR_W-1:0];
  assign ram_wdata = in_tdata[58:5];

  assign q_valid = (count_r != 2'd0);
  assign q_data  = qmem_r[rd_ptr_r];

  // Two-entry queue of orientations for the back end.
  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r] <= q_in;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cfmt_back.sv]
`default_nettype none
module cfmt_back #(
  parameter int SYM_COUNT = 24,
  parameter int FRAC_BITS = 16,
  localparam int ADDR_W = (SYM_COUNT > 1) ? $clog2(SYM_COUNT) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  input  wire cfmt_pkg::quat_t                     q_data,
  output logic                                     q_pop,
  output cfmt_pkg::back_status_t                   bk_status,
  input  wire logic signed [cfmt_pkg::CFG_W-1:0]   sample_x,
  input  wire logic signed [cfmt_pkg::CFG_W-1:0]   sample_y,
  input  wire logic signed [cfmt_pkg::CFG_W-1:0]   sample_z,
  input  wire logic signed [cfmt_pkg::CFG_W-1:0]   cos_tol,
  output logic [ADDR_W-1:0]                        ram_raddr,
  input  wire logic [cfmt_pkg::DIR_W-1:0]          ram_rdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [cfmt_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import cfmt_pkg::*;

  // Widths of each arithmetic stage.
  localparam int Q_W   = 2 * FIELD_W;
  localparam int P_W   = Q_W + 4;
  localparam int M_W   = P_W - FRAC_BITS;
  localparam int MD_W  = M_W + FIELD_W;
  localparam int A_W   = MD_W + 2;
  localparam int R_W   = A_W - FRAC_BITS;
  localparam int SR_W  = R_W + FIELD_W;
  localparam int D_W   = SR_W + 2;
  localparam int DOT_W = D_W - FRAC_BITS;

  localparam logic signed [P_W-1:0]   HALF_P = P_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [A_W-1:0]   HALF_A = A_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [D_W-1:0]   HALF_D = D_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DOT_W-1:0] ONE_Q  = DOT_W'(1) << FRAC_BITS;
  localparam logic [ADDR_W-1:0]       LAST_IDX = ADDR_W'(SYM_COUNT - 1);

  back_state_t state_r, state_nxt;
  quat_t       q_r;
  logic [ADDR_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic        issue;
  logic        load_out;

  // Quaternion products.
  logic signed [Q_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [P_W-1:0] qbar;
  logic signed [P_W-1:0] msum [9];
  logic signed [P_W-1:0] mrnd [9];
  logic signed [M_W-1:0] m_r [9];

  // Walk pipeline.
  logic rv_r, rf_r, rl_r;
  logic av_r, af_r, al_r;
  logic bv_r, bf_r, bl_r;
  logic cv_r, cf_r, cl_r;
  logic done_r;
  logic signed [FIELD_W-1:0] dvec [3];
  logic signed [MD_W-1:0]    ap_r [9];
  logic signed [A_W-1:0]     asum [3];
  logic signed [A_W-1:0]     arnd [3];
  logic signed [R_W-1:0]     r_r [3];
  logic signed [FIELD_W-1:0] svec [3];
  logic signed [SR_W-1:0]    cp_r [3];
  logic signed [D_W-1:0]     dsum;
  logic signed [D_W-1:0]     drnd;
  logic signed [DOT_W-1:0]   dot;
  logic signed [DOT_W-1:0]   best_r;
  logic signed [DOT_W-1:0]   sat;
  logic                      fiber;
  logic [OUT_TDATA_W-1:0]    out_data_r;
  logic                      out_valid_r;

  assign bk_status.busy    = (state_r != BK_IDLE);
  assign ram_raddr         = rd_cnt_r;
  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_data_r;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    q_pop      = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_MPROD;
        end
      end
      BK_MPROD: state_nxt = BK_MSUM;
      BK_MSUM: begin
        rd_cnt_nxt = '0;
        state_nxt  = BK_WALK;
      end
      BK_WALK: begin
        issue = 1'b1;
        if (rd_cnt_r == LAST_IDX) begin
          state_nxt = BK_DRAIN;
        end else begin
          rd_cnt_nxt = rd_cnt_r + ADDR_W'(1);
        end
      end
      BK_DRAIN: begin
        if (done_r) begin
          state_nxt = BK_SEND;
        end
      end
      BK_SEND: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      rd_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  // Quaternion capture and its ten products.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      q_r <= q_data;
    end
    if (state_r == BK_MPROD) begin
      ww_r <= q_r.w * q_r.w;
      xx_r <= q_r.x * q_r.x;
      yy_r <= q_r.y * q_r.y;
      zz_r <= q_r.z * q_r.z;
      xy_r <= q_r.x * q_r.y;
      wz_r <= q_r.w * q_r.z;
      xz_r <= q_r.x * q_r.z;
      wy_r <= q_r.w * q_r.y;
      yz_r <= q_r.y * q_r.z;
      wx_r <= q_r.w * q_r.x;
    end
  end

  // Rotation matrix, row-major, each entry rounded once.
  always_comb begin
    qbar    = P_W'(ww_r) - P_W'(xx_r) - P_W'(yy_r) - P_W'(zz_r);
    msum[0] = qbar + (P_W'(xx_r) <<< 1);
    msum[1] = (P_W'(xy_r) - P_W'(wz_r)) <<< 1;
    msum[2] = (P_W'(xz_r) + P_W'(wy_r)) <<< 1;
    msum[3] = (P_W'(xy_r) + P_W'(wz_r)) <<< 1;
    msum[4] = qbar + (P_W'(yy_r) <<< 1);
    msum[5] = (P_W'(yz_r) - P_W'(wx_r)) <<< 1;
    msum[6] = (P_W'(xz_r) - P_W'(wy_r)) <<< 1;
    msum[7] = (P_W'(yz_r) + P_W'(wx_r)) <<< 1;
    msum[8] = qbar + (P_W'(zz_r) <<< 1);
    for (int i = 0; i < 9; i++) begin
      mrnd[i] = msum[i] + HALF_P;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_MSUM) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= mrnd[i][P_W-1:FRAC_BITS];
      end
    end
  end

  // Table direction and sample direction as vectors.
  assign dvec[0] = ram_rdata[FIELD_W-1:0];
  assign dvec[1] = ram_rdata[2*FIELD_W-1:FIELD_W];
  assign dvec[2] = ram_rdata[3*FIELD_W-1:2*FIELD_W];
  assign svec[0] = sample_x;
  assign svec[1] = sample_y;
  assign svec[2] = sample_z;

  // Rotated components and the dot product with the sample direction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asum[i] = A_W'(ap_r[3*i]) + A_W'(ap_r[3*i+1]) + A_W'(ap_r[3*i+2]);
      arnd[i] = asum[i] + HALF_A;
    end
    dsum = D_W'(cp_r[0]) + D_W'(cp_r[1]) + D_W'(cp_r[2]);
    drnd = dsum + HALF_D;
    dot  = drnd[D_W-1:FRAC_BITS];
  end

  // Walk pipeline: table read, matrix products, rounding, dot products, maximum.
  always_ff @(posedge clk) begin
    if (rv_r) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ap_r[3*i+j] <= m_r[3*i+j] * dvec[j];
        end
      end
    end
    if (av_r) begin
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= arnd[i][A_W-1:FRAC_BITS];
      end
    end
    if (bv_r) begin
      for (int i = 0; i < 3; i++) begin
        cp_r[i] <= svec[i] * r_r[i];
      end
    end
    if (cv_r && (cf_r || (dot > best_r))) begin
      best_r <= dot;
    end
    if (!rst_n) begin
      rv_r   <= 1'b0;
      av_r   <= 1'b0;
      bv_r   <= 1'b0;
      cv_r   <= 1'b0;
      done_r <= 1'b0;
      rf_r   <= 1'b0;
      rl_r   <= 1'b0;
      af_r   <= 1'b0;
      al_r   <= 1'b0;
      bf_r   <= 1'b0;
      bl_r   <= 1'b0;
      cf_r   <= 1'b0;
      cl_r   <= 1'b0;
    end else begin
      rv_r   <= issue;
      rf_r   <= issue && (rd_cnt_r == '0);
      rl_r   <= issue && (rd_cnt_r == LAST_IDX);
      av_r   <= rv_r;
      af_r   <= rf_r;
      al_r   <= rl_r;
      bv_r   <= av_r;
      bf_r   <= af_r;
      bl_r   <= al_r;
      cv_r   <= bv_r;
      cf_r   <= bf_r;
      cl_r   <= bl_r;
      done_r <= cv_r && cl_r;
    end
  end

  // Saturate the maximum and compare with the tolerance.
  always_comb begin
    if (best_r > ONE_Q) begin
      sat = ONE_Q;
    end else if (best_r < -ONE_Q) begin
      sat = -ONE_Q;
    end else begin
      sat = best_r;
    end
    fiber = (sat >= DOT_W'(cos_tol));
  end

  // Output register; it frees the back end for the next orientation.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {(OUT_TDATA_W - FIELD_W - 1)'(0), fiber, sat[FIELD_W-1:0]};
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/crystal_fiber_membership_test.sv]
`default_nettype none
// Channel   Direction  tdata (low bit first)                                  tuser
// in_       in         entry_index, dir_x/y/z, quat_w/x/y/z, zero pad to 136   operation
// out_      out        max_cosine, fiber_hit, zero pad to 24                   -
// cfg_      in         register index 0..3, 18-bit data                        -
//
// A load item is held off until all queued classify work is finished. In the back
// end, a classify item walks through the direction table at one entry per cycle.
// Up to two orientations wait in the queue; a finished result waits in the output
// register while the next orientation is processed. Reset is synchronous, active
// low; the direction table is not cleared and must be loaded before classifying.
module crystal_fiber_membership_test #(
  parameter int SYM_COUNT = cfmt_pkg::SYM_COUNT_DEF,
  parameter int FRAC_BITS = cfmt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // entry_index, dir_x, dir_y, dir_z, quat_w, quat_x, quat_y, quat_z, pad
  input  wire logic [cfmt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // max_cosine, fiber_hit, pad
  output logic [cfmt_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cfmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cfmt_pkg::CFG_W-1:0]          cfg_data
);
  import cfmt_pkg::*;

  localparam int ADDR_W = (SYM_COUNT > 1) ? $clog2(SYM_COUNT) : 1;

  logic signed [CFG_W-1:0] sample_x_r;
  logic signed [CFG_W-1:0] sample_y_r;
  logic signed [CFG_W-1:0] sample_z_r;
  logic signed [CFG_W-1:0] cos_tol_r;
  back_status_t            bk_status;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [DIR_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [DIR_W-1:0]        ram_rdata;
  logic                    q_valid;
  quat_t                   q_data;
  logic                    q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_x_r <= '0;
      sample_y_r <= '0;
      sample_z_r <= CFG_W'(1) << FRAC_BITS;
      cos_tol_r  <= CFG_W'(1) << FRAC_BITS;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_X: sample_x_r <= cfg_data;
        REG_SAMPLE_Y: sample_y_r <= cfg_data;
        REG_SAMPLE_Z: sample_z_r <= cfg_data;
        REG_COS_TOL:  cos_tol_r  <= cfg_data;
        default:      sample_x_r <= sample_x_r;
      endcase
    end
  end

  cfmt_front #(.SYM_COUNT(SYM_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .bk_status (bk_status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  cfmt_ram #(.WIDTH(DIR_W), .DEPTH(SYM_COUNT)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cfmt_back #(.SYM_COUNT(SYM_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .bk_status  (bk_status),
    .sample_x   (sample_x_r),
    .sample_y   (sample_y_r),
    .sample_z   (sample_z_r),
    .cos_tol    (cos_tol_r),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[hw/rtl/cfmt_checker.sv]
`default_nettype none
`include "crystal_fiber_membership_test_defines.svh"
module cfmt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [cfmt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cfmt_pkg::*;

  localparam logic signed [FIELD_W:0] ONE_Q = (FIELD_W + 1)'(1) << FRAC_BITS_DEF;

  logic signed [FIELD_W:0] max_ext;
  assign max_ext = {out_tdata[FIELD_W-1], out_tdata[FIELD_W-1:0]};

  // A result never shows right after reset.
  `CFMT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")
  // A waiting result is not withdrawn.
  `CFMT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  // The reported maximum is saturated to the unit range.
  `CFMT_ASSERT(a_sat, out_tvalid |-> (max_ext <= ONE_Q) && (max_ext >= -ONE_Q), "not saturated")
  // Padding bits of the result stay zero.
  `CFMT_ASSERT(a_pad, out_tvalid |-> (out_tdata[OUT_TDATA_W-1:FIELD_W+1] == '0), "pad set")
  // The input ready is always a defined level while an item is offered.
  `CFMT_ASSERT(a_in_ready_known, in_tvalid |-> !$isunknown(in_tready), "input ready unknown")

endmodule

bind crystal_fiber_membership_test cfmt_checker u_cfmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
